FILE: hdl/virtual_timer_deadline_queue_assert.svh
// ---------------------------------------------------------------------------
// Timer deadline queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef VIRTUAL_TIMER_DEADLINE_QUEUE_ASSERT_SVH
`define VIRTUAL_TIMER_DEADLINE_QUEUE_ASSERT_SVH

// Same-cycle implication
`define VTDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define VTDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/vtdq_pkg.sv
// ---------------------------------------------------------------------------
// Timer deadline queue package
// Function codes, result kinds and the command passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package vtdq_pkg;

  // Input function codes
  localparam logic [1:0] FuncSched  = 2'd0;
  localparam logic [1:0] FuncCancel = 2'd1;
  localparam logic [1:0] FuncTick   = 2'd2;

  // Result kinds
  localparam logic KindAck    = 1'b0;
  localparam logic KindExpiry = 1'b1;

  // Field widths
  localparam int unsigned SlotW  = 4;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned PendW  = 5;

  // Expiries per tick and its counter width
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FireCntW   = $clog2(MaxResults);

  // Command queue depth
  localparam int unsigned CmdQDepth = 2;

  typedef struct packed {
    logic [1:0]       func;
    logic             slot_ok;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] span;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/vtdq_cmd_fifo.sv
// ---------------------------------------------------------------------------
// Timer deadline queue command FIFO
// Short queue between the classifying front and the executing back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "virtual_timer_deadline_queue_assert.svh"

module vtdq_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire vtdq_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output vtdq_pkg::cmd_t      pop_cmd_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (vtdq_pkg::CmdQDepth > 1) ? $clog2(vtdq_pkg::CmdQDepth) : 1;
  localparam int unsigned CntW = $clog2(vtdq_pkg::CmdQDepth + 1);

  vtdq_pkg::cmd_t  mem_q [vtdq_pkg::CmdQDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Flags and read data
  always_comb begin
    full_o    = (cnt_q == CntW'(vtdq_pkg::CmdQDepth));
    empty_o   = (cnt_q == '0);
    pop_cmd_o = mem_q[rd_ptr_q];
  end

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(vtdq_pkg::CmdQDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(vtdq_pkg::CmdQDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `VTDQ_ASSERT_IMP(a_no_push_when_full, push_i, !full_o, "command pushed into a full queue")
  `VTDQ_ASSERT_IMP(a_no_pop_when_empty, pop_i, !empty_o, "command popped from an empty queue")

endmodule

`default_nettype wire

FILE: hdl/vtdq_front.sv
// ---------------------------------------------------------------------------
// Timer deadline queue front end
// Accepts input items, drops unused codes, scales millisecond delays and
// pushes commands into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module vtdq_front #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [vtdq_pkg::SlotW-1:0]    timer_slot_i,
  input  wire logic [vtdq_pkg::TimeW-1:0]    delay_i,
  input  wire logic                          delay_in_ms_i,
  input  wire logic [vtdq_pkg::CfgW-1:0]     ticks_per_ms_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output vtdq_pkg::cmd_t                     q_cmd_o
);

  localparam int unsigned ProdW = vtdq_pkg::TimeW + vtdq_pkg::CfgW;

  logic                         fr_valid_q, fr_valid_d;
  logic [1:0]                   fr_func_q;
  logic [vtdq_pkg::SlotW-1:0]   fr_slot_q;
  logic [vtdq_pkg::TimeW-1:0]   fr_delay_q;
  logic                         fr_ms_q;
  logic                         accept, is_op, drop;
  logic [ProdW-1:0]             prod;

  // Classify the held item and decide whether it leaves this cycle
  always_comb begin
    is_op      = (fr_func_q == vtdq_pkg::FuncSched) || (fr_func_q == vtdq_pkg::FuncCancel) ||
                 (fr_func_q == vtdq_pkg::FuncTick);
    q_push_o   = fr_valid_q && is_op && !q_full_i;
    drop       = fr_valid_q && !is_op;
    in_stall_o = fr_valid_q && !(q_push_o || drop);
    accept     = in_valid_i && !in_stall_o;
    fr_valid_d = accept ? 1'b1 : ((q_push_o || drop) ? 1'b0 : fr_valid_q);
  end

  // Scale millisecond delays, wrapping to 32 bits
  always_comb begin
    prod             = ProdW'(fr_delay_q) * ProdW'(ticks_per_ms_i);
    q_cmd_o.func     = fr_func_q;
    q_cmd_o.slot_ok  = (32'(fr_slot_q) < 32'(TIMER_SLOTS));
    q_cmd_o.slot     = fr_slot_q;
    q_cmd_o.span     = fr_ms_q ? prod[vtdq_pkg::TimeW-1:0] : fr_delay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_func_q  <= func_i;
      fr_slot_q  <= timer_slot_i;
      fr_delay_q <= delay_i;
      fr_ms_q    <= delay_in_ms_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vtdq_back.sv
// ---------------------------------------------------------------------------
// Timer deadline queue back end
// Runs commands over the slot table: unlink, one-slot-per-cycle scan,
// link or fire, and a registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "virtual_timer_deadline_queue_assert.svh"

module vtdq_back #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  wire vtdq_pkg::cmd_t                q_cmd_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [vtdq_pkg::SlotW-1:0]         fired_slot_o,
  output logic                               last_of_run_o,
  output logic [vtdq_pkg::TimeW-1:0]         current_time_o,
  output logic [vtdq_pkg::PendW-1:0]         pending_count_o,
  output logic                               queue_nonempty_o,
  output logic [vtdq_pkg::TimeW-1:0]         next_deadline_o
);

  localparam int unsigned SlotIdxW = $clog2(TIMER_SLOTS);
  localparam int unsigned CntW     = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned TW       = vtdq_pkg::TimeW;
  localparam int unsigned FW       = vtdq_pkg::FireCntW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StUnlink = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StFinish = 3'd3;
  localparam logic [2:0] StFire   = 3'd4;

  logic [2:0]             state_q, state_d;
  vtdq_pkg::cmd_t         cmd_q;
  logic [TW-1:0]          dl_q;
  logic [TW-1:0]          tick_now_q;
  logic [TW-1:0]          deadline_q [TIMER_SLOTS];
  logic [SlotIdxW-1:0]    rank_q [TIMER_SLOTS];
  logic [SlotIdxW-1:0]    rank_d [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] active_q, active_d;
  logic [CntW-1:0]        count_q, count_d;

  // Scan results
  logic [SlotIdxW-1:0]    scan_q;
  logic [CntW-1:0]        pos_q;
  logic                   h0_v_q, h1_v_q;
  logic [SlotIdxW-1:0]    h0_slot_q;
  logic [TW-1:0]          h0_dl_q, h1_dl_q;
  logic [FW-1:0]          fire_n_q;

  logic [SlotIdxW-1:0]    sidx, rd_idx, rank_rd;
  logic [TW-1:0]          dl_rd;
  logic                   do_unlink, do_link, fire_due, fire_last;
  logic                   emit_req, out_load, scan_start, scan_end;

  // Result under construction
  logic                   em_kind, em_last;
  logic [vtdq_pkg::SlotW-1:0] em_slot;
  logic [CntW-1:0]        em_count;
  logic [TW-1:0]          em_next;

  // Result register
  logic                   out_valid_q;
  logic                   out_kind_q, out_last_q, out_nonempty_q;
  logic [vtdq_pkg::SlotW-1:0] out_slot_q;
  logic [TW-1:0]          out_time_q, out_next_q;
  logic [vtdq_pkg::PendW-1:0] out_pend_q;

  // Table read port and command decode
  always_comb begin
    q_pop_o   = (state_q == StIdle) && !q_empty_i;
    sidx      = SlotIdxW'(cmd_q.slot);
    rd_idx    = (state_q == StUnlink) ? sidx : scan_q;
    rank_rd   = rank_q[rd_idx];
    dl_rd     = deadline_q[scan_q];
    do_unlink = cmd_q.slot_ok && active_q[sidx];
    do_link   = (cmd_q.func == vtdq_pkg::FuncSched) && cmd_q.slot_ok;
    fire_due  = h0_v_q && (h0_dl_q <= tick_now_q);
    fire_last = !(h1_v_q && (h1_dl_q <= tick_now_q)) ||
                (fire_n_q == FW'(vtdq_pkg::MaxResults - 1));
    scan_end  = (scan_q == SlotIdxW'(TIMER_SLOTS - 1));
    emit_req  = (state_q == StFinish) || ((state_q == StFire) && fire_due);
    out_load  = emit_req && (!out_valid_q || !out_stall_i);
    scan_start = (q_pop_o && (q_cmd_i.func == vtdq_pkg::FuncTick)) ||
                 (state_q == StUnlink) ||
                 ((state_q == StFire) && out_load && !fire_last);
  end

  // Build the result: expiry of the head, or acknowledgement
  always_comb begin
    if (state_q == StFire) begin
      em_kind  = vtdq_pkg::KindExpiry;
      em_slot  = vtdq_pkg::SlotW'(h0_slot_q);
      em_last  = fire_last;
      em_count = count_q - CntW'(1);
      em_next  = h1_v_q ? h1_dl_q : '0;
    end else begin
      em_kind  = vtdq_pkg::KindAck;
      em_slot  = cmd_q.slot;
      em_last  = 1'b1;
      em_count = count_q + CntW'(do_link);
      if (do_link && (pos_q == '0)) begin
        em_next = dl_q;
      end else begin
        em_next = h0_v_q ? h0_dl_q : '0;
      end
    end
  end

  // Sequence one command
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          state_d = (q_cmd_i.func == vtdq_pkg::FuncTick) ? StScan : StUnlink;
        end
      end
      StUnlink: begin
        state_d = StScan;
      end
      StScan: begin
        if (scan_end) begin
          state_d = (cmd_q.func == vtdq_pkg::FuncTick) ? StFire : StFinish;
        end
      end
      StFinish: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      StFire: begin
        if (!fire_due) begin
          state_d = StIdle;
        end else if (out_load) begin
          state_d = fire_last ? StIdle : StScan;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Unlink, fire and link update ranks of every slot in parallel
  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      rank_d[i] = rank_q[i];
    end
    case (state_q)
      StUnlink: begin
        if (do_unlink) begin
          count_d = count_q - CntW'(1);
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (SlotIdxW'(i) == sidx) begin
              active_d[i] = 1'b0;
            end else if (active_q[i] && (rank_q[i] > rank_rd)) begin
              rank_d[i] = rank_q[i] - SlotIdxW'(1);
            end
          end
        end
      end
      StFire: begin
        if (out_load) begin
          count_d = count_q - CntW'(1);
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (SlotIdxW'(i) == h0_slot_q) begin
              active_d[i] = 1'b0;
            end else if (active_q[i] && (rank_q[i] != '0)) begin
              rank_d[i] = rank_q[i] - SlotIdxW'(1);
            end
          end
        end
      end
      StFinish: begin
        if (out_load && do_link) begin
          count_d = count_q + CntW'(1);
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (SlotIdxW'(i) == sidx) begin
              active_d[i] = 1'b1;
              rank_d[i]   = SlotIdxW'(pos_q);
            end else if (active_q[i] && (CntW'(rank_q[i]) >= pos_q)) begin
              rank_d[i] = rank_q[i] + SlotIdxW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_now_q  <= '0;
      active_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      fire_n_q    <= '0;
      scan_q      <= '0;
      h0_v_q      <= 1'b0;
      h1_v_q      <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      count_q  <= count_d;

      // Advance time on a tick
      if (q_pop_o && (q_cmd_i.func == vtdq_pkg::FuncTick)) begin
        tick_now_q <= tick_now_q + TW'(1);
        fire_n_q   <= '0;
      end else if ((state_q == StFire) && out_load) begin
        fire_n_q <= fire_n_q + FW'(1);
      end

      // Scan one slot per cycle for head, second and insert position
      if (scan_start) begin
        scan_q <= '0;
        h0_v_q <= 1'b0;
        h1_v_q <= 1'b0;
        pos_q  <= '0;
      end else if (state_q == StScan) begin
        scan_q <= scan_q + SlotIdxW'(1);
        if (active_q[scan_q]) begin
          if (rank_rd == '0) begin
            h0_v_q <= 1'b1;
          end
          if (rank_rd == SlotIdxW'(1)) begin
            h1_v_q <= 1'b1;
          end
          if (dl_rd <= dl_q) begin
            pos_q <= pos_q + CntW'(1);
          end
        end
      end

      // Hold the result until transferred
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
      dl_q  <= tick_now_q + q_cmd_i.span;
    end
    if ((state_q == StScan) && active_q[scan_q]) begin
      if (rank_rd == '0) begin
        h0_slot_q <= scan_q;
        h0_dl_q   <= dl_rd;
      end
      if (rank_rd == SlotIdxW'(1)) begin
        h1_dl_q <= dl_rd;
      end
    end
    if ((state_q == StFinish) && out_load && do_link) begin
      deadline_q[sidx] <= dl_q;
    end
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      rank_q[i] <= rank_d[i];
    end
    if (out_load) begin
      out_kind_q     <= em_kind;
      out_slot_q     <= em_slot;
      out_last_q     <= em_last;
      out_time_q     <= tick_now_q;
      out_pend_q     <= vtdq_pkg::PendW'(em_count);
      out_nonempty_q <= (em_count != '0);
      out_next_q     <= em_next;
    end
  end

  always_comb begin
    out_valid_o      = out_valid_q;
    result_kind_o    = out_kind_q;
    fired_slot_o     = out_slot_q;
    last_of_run_o    = out_last_q;
    current_time_o   = out_time_q;
    pending_count_o  = out_pend_q;
    queue_nonempty_o = out_nonempty_q;
    next_deadline_o  = out_next_q;
  end

  `VTDQ_ASSERT_IMP(a_count_matches_active, 1'b1,
                   count_q == CntW'($countones(active_q)),
                   "active count out of step with active flags")
  `VTDQ_ASSERT_NXT(a_tick_advances, q_pop_o && (q_cmd_i.func == vtdq_pkg::FuncTick),
                   tick_now_q == $past(tick_now_q) + 32'd1,
                   "tick did not advance time by one")
  `VTDQ_ASSERT_NXT(a_pending_reported, out_load,
                   out_pend_q == vtdq_pkg::PendW'(count_q),
                   "reported pending count differs from table")

endmodule

`default_nettype wire

FILE: hdl/virtual_timer_deadline_queue.sv
// A schedule or cancel passes the front register, the command queue, the unlink, scan
//   and finish states and the result register before its acknowledgement; a tick scans
//   the table in the scan state and gives its first expiry from the fire state.
// The back end takes the next command only when idle; the one-slot-per-cycle scan
//   of the slot table in the back end runs again before each further expiry.
// Reset: asynchronous, all slots idle, time zero, ticks_per_ms 32; no clearing pass.
// ---------------------------------------------------------------------------
// Virtual timer deadline queue
// Timer slots multiplexed off one tick counter, fired in deadline order.
// Front end classifies items, a command queue decouples it from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module virtual_timer_deadline_queue #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vtdq_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [vtdq_pkg::SlotW-1:0]    timer_slot_i,
  input  wire logic [vtdq_pkg::TimeW-1:0]    delay_i,
  input  wire logic                          delay_in_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [vtdq_pkg::SlotW-1:0]         fired_slot_o,
  output logic                               last_of_run_o,
  output logic [vtdq_pkg::TimeW-1:0]         current_time_o,
  output logic [vtdq_pkg::PendW-1:0]         pending_count_o,
  output logic                               queue_nonempty_o,
  output logic [vtdq_pkg::TimeW-1:0]         next_deadline_o
);

  logic [vtdq_pkg::CfgW-1:0] ticks_per_ms_q;
  logic                      q_push, q_pop, q_full, q_empty;
  vtdq_pkg::cmd_t            push_cmd, pop_cmd;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_ms_q <= vtdq_pkg::CfgW'(32);
    end else if (cfg_valid_i && cfg_ready_o) begin
      ticks_per_ms_q <= cfg_data_i;
    end
  end

  vtdq_front #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .timer_slot_i   (timer_slot_i),
    .delay_i        (delay_i),
    .delay_in_ms_i  (delay_in_ms_i),
    .ticks_per_ms_i (ticks_per_ms_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  vtdq_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  vtdq_back #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_cmd_i          (pop_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .fired_slot_o     (fired_slot_o),
    .last_of_run_o    (last_of_run_o),
    .current_time_o   (current_time_o),
    .pending_count_o  (pending_count_o),
    .queue_nonempty_o (queue_nonempty_o),
    .next_deadline_o  (next_deadline_o)
  );

endmodule

`default_nettype wire
